[sv/frame_builder_xor_parity_top_assert.svh]
// Assertion macros used by the frame builder top level.
`ifndef FRAME_BUILDER_XOR_PARITY_TOP_ASSERT_SVH
`define FRAME_BUILDER_XOR_PARITY_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBX_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBX_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fbx_pkg.sv]
// Types and constants of the byte framer with XOR parity.
package fbx_pkg;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned IDX_W       = 2;

  localparam logic [7:0] MARKER_BYTE = 8'h7E;
  localparam logic [2:0] LOW3_MASK   = 3'h7;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // One command transfer.
  typedef struct packed {
    logic       command;
    logic [4:0] frame_type;
    logic [5:0] sequence_req;
    logic [4:0] frame_length;
    logic [7:0] data_byte;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       protocol_error;
    logic       run_last;
  } out_t;

  // All results caused by one command.
  typedef struct packed {
    out_t [MAX_RESULTS-1:0] entry;
    logic [IDX_W-1:0]       last;
  } burst_t;

  // Serializer status seen by the top level.
  typedef struct packed {
    logic busy;
    logic final_xfer;
  } ser_stat_t;

endpackage

[sv/fbx_frame_ctl.sv]
// Frame state and result generation for one accepted command.
module fbx_frame_ctl (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  fbx_pkg::in_t   cmd,
  output fbx_pkg::burst_t burst
);

  logic       frame_open;
  logic [4:0] bytes_remaining;
  logic [7:0] running_parity;

  logic       frame_open_next;
  logic [4:0] bytes_remaining_next;
  logic [7:0] running_parity_next;

  logic [7:0] h1;
  logic [7:0] h2;
  logic [7:0] hdr_par;
  logic [7:0] data_par;
  logic [4:0] rem_dec;

  assign h1       = {cmd.frame_length, cmd.sequence_req[5:3]};
  assign h2       = {cmd.sequence_req[2:0] & fbx_pkg::LOW3_MASK, cmd.frame_type};
  assign hdr_par  = h1 ^ h2;
  assign data_par = running_parity ^ cmd.data_byte;
  assign rem_dec  = bytes_remaining - 5'd1;

  // Build the burst and the next frame state
  always_comb begin
    burst                = '0;
    frame_open_next      = frame_open;
    bytes_remaining_next = bytes_remaining;
    running_parity_next  = running_parity;
    case (cmd.command)
      fbx_pkg::CMD_START: begin
        burst.entry[0] = '{fbx_pkg::MARKER_BYTE, 1'b1, 1'b0, frame_open, 1'b0};
        burst.entry[1] = '{h1, 1'b1, 1'b0, frame_open, 1'b0};
        burst.entry[2] = '{h2, 1'b1, 1'b0, frame_open, 1'b0};
        bytes_remaining_next = cmd.frame_length;
        if (cmd.frame_length == 5'd0) begin
          // empty frame closes at once
          burst.entry[3]      = '{hdr_par, 1'b1, 1'b1, frame_open, 1'b1};
          burst.last          = 2'd3;
          frame_open_next     = 1'b0;
          running_parity_next = 8'h00;
        end else begin
          burst.entry[2].run_last = 1'b1;
          burst.last              = 2'd2;
          frame_open_next         = 1'b1;
          running_parity_next     = hdr_par;
        end
      end
      fbx_pkg::CMD_DATA: begin
        if (!frame_open) begin
          // stray data byte: error-only result
          burst.entry[0] = '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1};
          burst.last     = 2'd0;
        end else begin
          burst.entry[0]       = '{cmd.data_byte, 1'b1, 1'b0, 1'b0, 1'b0};
          bytes_remaining_next = rem_dec;
          if (rem_dec == 5'd0) begin
            burst.entry[1]      = '{data_par, 1'b1, 1'b1, 1'b0, 1'b1};
            burst.last          = 2'd1;
            frame_open_next     = 1'b0;
            running_parity_next = 8'h00;
          end else begin
            burst.entry[0].run_last = 1'b1;
            burst.last              = 2'd0;
            running_parity_next     = data_par;
          end
        end
      end
      default: begin
        burst = '0;
      end
    endcase
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= 5'd0;
      running_parity  <= 8'h00;
    end else if (accept) begin
      frame_open      <= frame_open_next;
      bytes_remaining <= bytes_remaining_next;
      running_parity  <= running_parity_next;
    end
  end

endmodule

[sv/fbx_burst_out.sv]
// Result register that hands out a burst one transfer per cycle while res_stall is low.
module fbx_burst_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  fbx_pkg::burst_t    burst,
  output logic               res_valid,
  input  logic               res_stall,
  output fbx_pkg::out_t      res,
  output fbx_pkg::ser_stat_t stat
);

  logic                                      busy;
  logic [fbx_pkg::IDX_W-1:0]                 idx;
  fbx_pkg::burst_t                           held;
  logic                                      take;

  assign take            = busy && !res_stall;
  assign stat.busy       = busy;
  assign stat.final_xfer = take && (idx == held.last);
  assign res_valid       = busy;
  assign res             = held.entry[idx];

  // Control: busy flag and transfer index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (stat.final_xfer) begin
      busy <= 1'b0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= burst;
    end
  end

endmodule

[sv/frame_builder_xor_parity_top.sv]
// Top level of the byte framer with XOR parity.
//
// Command channel (cmd_valid / cmd_stall / cmd): a start command opens a
// frame and yields marker 0x7E plus two header bytes; data commands pass one
// payload byte each. After frame_length data bytes the XOR parity byte of the
// header and data bytes follows with frame_end set. Stray data and a start on
// an open frame raise protocol_error.
// Result channel (res_valid / res_stall / res): one byte per transfer;
// run_last marks the final result of each command.
// Flow: the first result of a command is shown in the cycle after its
// transfer. A command yields 1 to 4 results, one per cycle unless res_stall
// holds them; the next command is taken in the cycle its predecessor's last
// result transfers, so unstalled data commands stream at one per cycle. A
// closing data command gives 2 results, a start 3 or 4, all held in the single result register.
// Reset (rst, synchronous) closes any frame, clears parity and drops
// res_valid. While res_stall is high the current result holds and cmd_stall
// stays high once the burst register is occupied.
`include "frame_builder_xor_parity_top_assert.svh"

module frame_builder_xor_parity_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  fbx_pkg::in_t  cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output fbx_pkg::out_t res
);

  fbx_pkg::burst_t    burst;
  fbx_pkg::ser_stat_t stat;
  logic               accept;

  // Free when empty or when the last result leaves this cycle
  assign cmd_stall = stat.busy && !stat.final_xfer;
  assign accept    = cmd_valid && !cmd_stall;

  fbx_frame_ctl u_ctl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .burst  (burst)
  );

  fbx_burst_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst     (burst),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .stat      (stat)
  );

  `FBX_ASSERT_IMP(a_parity_last, clk, rst, res_valid && res.frame_end,
                  res.run_last, "parity byte not last")
  `FBX_ASSERT_IMP(a_err_only, clk, rst, res_valid && !res.byte_valid,
                  res.protocol_error && res.run_last, "bad error-only result")
  `FBX_ASSERT_NXT(a_load_shows, clk, rst, accept, res_valid, "burst not shown")

endmodule

[tb/sv/frame_stream_monitor.sv]
// Watches both channels of the frame builder, predicts each frame byte and compares.
`timescale 1ns / 100ps

module frame_stream_monitor (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_stall,
  input  fbx_pkg::in_t  cmd,
  input  logic          res_valid,
  input  logic          res_stall,
  input  fbx_pkg::out_t res,
  output int unsigned   mismatches,
  output int unsigned   bytes_pending
);

  // Predicted framer state
  logic       frame_is_open;
  logic [4:0] payload_left;
  logic [7:0] parity_acc;

  fbx_pkg::out_t frame_bytes_due[$];
  int unsigned   fail_tally;

  initial begin
    frame_is_open = 1'b0;
    payload_left  = '0;
    parity_acc    = '0;
    fail_tally    = 0;
    mismatches    = 0;
    bytes_pending = 0;
  end

  task automatic queue_byte(logic [7:0] b, logic v, logic e, logic err, logic last);
    fbx_pkg::out_t r;
    r.out_byte       = b;
    r.byte_valid     = v;
    r.frame_end      = e;
    r.protocol_error = err;
    r.run_last       = last;
    frame_bytes_due.push_back(r);
  endtask

  // Expected bytes for one accepted command
  task automatic predict_frame_bytes(fbx_pkg::in_t c);
    logic       err;
    logic [7:0] hdr_hi;
    logic [7:0] hdr_lo;
    if (c.command == fbx_pkg::CMD_START) begin
      err    = frame_is_open;
      hdr_hi = {c.frame_length, c.sequence_req[5:3]};
      hdr_lo = {c.sequence_req[2:0], c.frame_type};
      queue_byte(fbx_pkg::MARKER_BYTE, 1'b1, 1'b0, err, 1'b0);
      queue_byte(hdr_hi, 1'b1, 1'b0, err, 1'b0);
      parity_acc   = hdr_hi ^ hdr_lo;
      payload_left = c.frame_length;
      if (c.frame_length == 5'd0) begin
        // zero-length frame closes at once
        queue_byte(hdr_lo, 1'b1, 1'b0, err, 1'b0);
        queue_byte(parity_acc, 1'b1, 1'b1, err, 1'b1);
        frame_is_open = 1'b0;
        parity_acc    = '0;
      end else begin
        queue_byte(hdr_lo, 1'b1, 1'b0, err, 1'b1);
        frame_is_open = 1'b1;
      end
    end else if (!frame_is_open) begin
      // stray payload byte: error-only result
      queue_byte(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    end else begin
      parity_acc   = parity_acc ^ c.data_byte;
      payload_left = payload_left - 5'd1;
      if (payload_left == 5'd0) begin
        queue_byte(c.data_byte, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_byte(parity_acc, 1'b1, 1'b1, 1'b0, 1'b1);
        frame_is_open = 1'b0;
        parity_acc    = '0;
      end else begin
        queue_byte(c.data_byte, 1'b1, 1'b0, 1'b0, 1'b1);
      end
    end
  endtask

  task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    fbx_pkg::out_t want;
    if (rst) begin
      frame_is_open = 1'b0;
      payload_left  = '0;
      parity_acc    = '0;
      frame_bytes_due.delete();
    end else begin
      // result side first: a result never belongs to a command taken at the same edge
      if (res_valid && !res_stall) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, res);
          fail_tally++;
        end else begin
          want = frame_bytes_due.pop_front();
          check_field("out_byte", want.out_byte, res.out_byte);
          check_field("byte_valid", 8'(want.byte_valid), 8'(res.byte_valid));
          check_field("frame_end", 8'(want.frame_end), 8'(res.frame_end));
          check_field("protocol_error", 8'(want.protocol_error),
                      8'(res.protocol_error));
          check_field("run_last", 8'(want.run_last), 8'(res.run_last));
        end
      end
      if (cmd_valid && !cmd_stall) predict_frame_bytes(cmd);
    end
    mismatches    <= fail_tally;
    bytes_pending <= frame_bytes_due.size();
  end

endmodule

[tb/sv/testbench.sv]
// Stimulus, receiver back-pressure and verdict for the frame builder.
`timescale 1ns / 100ps

module testbench;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cmd_valid = 1'b0;
  fbx_pkg::in_t  cmd       = '0;
  logic          res_stall = 1'b0;
  logic          cmd_stall;
  logic          res_valid;
  fbx_pkg::out_t res;

  int unsigned mismatches;
  int unsigned bytes_pending;
  int unsigned cmds_sent = 0;
  bit          send_steady = 1'b0;

  always #5 clk = ~clk;

  frame_builder_xor_parity_top uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  frame_stream_monitor monitor_i (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res           (res),
    .mismatches    (mismatches),
    .bytes_pending (bytes_pending)
  );

  function automatic fbx_pkg::in_t make_cmd(logic c, logic [4:0] ft, logic [5:0] sq,
                                            logic [4:0] ln, logic [7:0] db);
    fbx_pkg::in_t item;
    item.command      = c;
    item.frame_type   = ft;
    item.sequence_req = sq;
    item.frame_length = ln;
    item.data_byte    = db;
    return item;
  endfunction

  function automatic fbx_pkg::in_t rand_cmd(logic c, logic [4:0] ln);
    return make_cmd(c, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)), ln,
                    8'($urandom_range(0, 255)));
  endfunction

  // Offer one command and hold it until the transfer
  task automatic send_cmd(fbx_pkg::in_t item);
    int gap;
    gap = send_steady ? 0 : int'($urandom_range(0, 19));
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= item;
    @(posedge clk);
    while (!(cmd_valid && !cmd_stall)) @(posedge clk);
    cmds_sent++;
  endtask

  // Command side
  initial begin
    int len;
    int n;
    int kind;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: stray data, zero-length extremes, short frames, aborts
    send_cmd(make_cmd(fbx_pkg::CMD_DATA, 5'd31, 6'd63, 5'd31, 8'hFF));
    send_cmd(make_cmd(fbx_pkg::CMD_START, 5'd31, 6'd63, 5'd0, 8'hFF));
    send_cmd(make_cmd(fbx_pkg::CMD_START, 5'd0, 6'd0, 5'd0, 8'h00));
    send_cmd(make_cmd(fbx_pkg::CMD_START, 5'd5, 6'h2A, 5'd1, 8'h00));
    send_cmd(make_cmd(fbx_pkg::CMD_DATA, 5'd0, 6'd0, 5'd0, 8'h00));
    send_cmd(make_cmd(fbx_pkg::CMD_START, 5'h15, 6'h15, 5'd2, 8'h00));
    send_cmd(make_cmd(fbx_pkg::CMD_DATA, 5'd31, 6'd63, 5'd31, 8'hFF));
    send_cmd(make_cmd(fbx_pkg::CMD_START, 5'h0A, 6'h2A, 5'd3, 8'h5A));
    send_cmd(make_cmd(fbx_pkg::CMD_DATA, 5'd0, 6'd0, 5'd0, 8'hA5));
    send_cmd(make_cmd(fbx_pkg::CMD_DATA, 5'd0, 6'd0, 5'd0, 8'h80));
    send_cmd(make_cmd(fbx_pkg::CMD_DATA, 5'd0, 6'd0, 5'd0, 8'h01));
    send_cmd(make_cmd(fbx_pkg::CMD_START, 5'd1, 6'd1, 5'd2, 8'h00));
    send_cmd(make_cmd(fbx_pkg::CMD_DATA, 5'd0, 6'd0, 5'd0, 8'h3C));
    send_cmd(make_cmd(fbx_pkg::CMD_START, 5'd30, 6'd62, 5'd0, 8'h00));
    send_cmd(make_cmd(fbx_pkg::CMD_DATA, 5'd0, 6'd0, 5'd0, 8'h77));
    send_cmd(make_cmd(fbx_pkg::CMD_START, 5'd16, 6'd32, 5'd16, 8'h00));
    send_cmd(make_cmd(fbx_pkg::CMD_START, 5'd2, 6'd4, 5'd8, 8'h00));
    send_cmd(make_cmd(fbx_pkg::CMD_START, 5'd0, 6'd0, 5'd0, 8'h00));

    // random: mostly complete frames, some cut short, some noise
    while (cmds_sent < 258) begin
      send_steady = ($urandom_range(0, 3) == 0);
      kind = int'($urandom_range(0, 9));
      if (kind < 8) begin
        if ($urandom_range(0, 19) == 0) len = 31;
        else if ($urandom_range(0, 7) == 0) len = int'($urandom_range(0, 31));
        else len = int'($urandom_range(0, 5));
        n = len;
        if ($urandom_range(0, 9) == 0) n = int'($urandom_range(0, len));
        send_cmd(rand_cmd(fbx_pkg::CMD_START, 5'(len)));
        repeat (n) send_cmd(rand_cmd(fbx_pkg::CMD_DATA, 5'($urandom_range(0, 31))));
      end else if (kind == 8) begin
        send_cmd(rand_cmd(fbx_pkg::CMD_DATA, 5'($urandom_range(0, 31))));
      end else begin
        send_cmd(rand_cmd(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31))));
      end
    end
    cmd_valid <= 1'b0;

    // drain, then allow the pipeline to settle
    do @(posedge clk); while (bytes_pending != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** frame_builder_xor_parity_top: PASSED **");
    end else begin
      $display("** frame_builder_xor_parity_top: FAILED **");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back up the block
  initial begin
    int gap;
    int taken;
    bit steady;
    taken  = 0;
    steady = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = steady ? 0 : int'($urandom_range(0, 19));
      if (taken == 40) gap = 300;
      if (gap > 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        res_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(res_valid && !res_stall)) @(posedge clk);
      taken++;
      if (taken % 16 == 0) steady = ($urandom_range(0, 2) == 0);
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("** frame_builder_xor_parity_top: FAILED **");
    $finish;
  end

endmodule
